// ----- rtl/rsc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package rsc_pkg;

	// Fixed sizes of the scanner.
	localparam int SLOTS        = 8;
	localparam int SLOT_W       = 3;
	localparam int SHORT_POINTS = 13;
	localparam int LONG_POINTS  = 15;
	localparam int IDX_W        = 4;
	localparam int VOLT_W       = 16;
	localparam int CM_W         = 8;
	localparam int MM_W         = 11;
	localparam int QUO_W        = 11;
	localparam int NUM_W        = MM_W + VOLT_W;
	localparam int REM_W        = NUM_W + 1;
	localparam int DSH_W        = VOLT_W + QUO_W - 1;
	localparam int CNT_W        = 4;
	localparam int PROD_W       = 24;

	// mm / 10 is taken as (mm * 6554) >> 16, exact for mm below 1638.
	localparam logic [12:0] RECIP_10 = 13'd6554;

	localparam logic [SLOT_W-1:0] ECHO_SLOT = SLOT_W'(SLOTS - 1);
	localparam logic [SLOT_W-1:0] MUX_LAST  = 3'd6;

	localparam logic [2:0] FUNC_START  = 3'd0;
	localparam logic [2:0] FUNC_SAMPLE = 3'd1;
	localparam logic [2:0] FUNC_ECHO   = 3'd2;
	localparam logic [2:0] FUNC_TICK   = 3'd3;
	localparam logic [2:0] FUNC_CLEAR  = 3'd4;

	localparam logic CFG_LONG_SLOT = 1'b0;
	localparam logic CFG_LAST_SLOT = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOOK,
		ST_SEARCH,
		ST_MUL,
		ST_PREP,
		ST_DIV,
		ST_SUB,
		ST_SCALE,
		ST_COMMIT
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic look;
		logic search;
		logic mul;
		logic prep;
		logic div;
		logic sub;
		logic scale;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic is_sample;
		logic clamp;
		logic hit;
		logic div_last;
		logic out_free;
	} dp_status_t;

	function automatic logic [VOLT_W-1:0] bp_volt(input logic long_sel,
			input logic [IDX_W-1:0] idx);
		logic [VOLT_W-1:0] r;
		r = '0;
		if (long_sel) begin
			unique case (idx)
				4'd0:  r = 16'd36045;
				4'd1:  r = 16'd33423;
				4'd2:  r = 16'd26214;
				4'd3:  r = 16'd20316;
				4'd4:  r = 16'd16384;
				4'd5:  r = 16'd14025;
				4'd6:  r = 16'd11141;
				4'd7:  r = 16'd10486;
				4'd8:  r = 16'd9830;
				4'd9:  r = 16'd8520;
				4'd10: r = 16'd7864;
				4'd11: r = 16'd7209;
				4'd12: r = 16'd6554;
				4'd13: r = 16'd5898;
				4'd14: r = 16'd5505;
				default: r = '0;
			endcase
		end else begin
			unique case (idx)
				4'd0:  r = 16'd41288;
				4'd1:  r = 16'd39059;
				4'd2:  r = 16'd36045;
				4'd3:  r = 16'd30278;
				4'd4:  r = 16'd21496;
				4'd5:  r = 16'd17170;
				4'd6:  r = 16'd14156;
				4'd7:  r = 16'd12059;
				4'd8:  r = 16'd9699;
				4'd9:  r = 16'd7995;
				4'd10: r = 16'd6685;
				4'd11: r = 16'd5898;
				4'd12: r = 16'd5374;
				default: r = '0;
			endcase
		end
		return r;
	endfunction

	function automatic logic [CM_W-1:0] bp_cm(input logic long_sel,
			input logic [IDX_W-1:0] idx);
		logic [CM_W-1:0] r;
		r = '0;
		if (long_sel) begin
			unique case (idx)
				4'd0:  r = 8'd15;
				4'd1:  r = 8'd20;
				4'd2:  r = 8'd30;
				4'd3:  r = 8'd40;
				4'd4:  r = 8'd50;
				4'd5:  r = 8'd60;
				4'd6:  r = 8'd70;
				4'd7:  r = 8'd80;
				4'd8:  r = 8'd90;
				4'd9:  r = 8'd100;
				4'd10: r = 8'd110;
				4'd11: r = 8'd120;
				4'd12: r = 8'd130;
				4'd13: r = 8'd140;
				4'd14: r = 8'd150;
				default: r = '0;
			endcase
		end else begin
			unique case (idx)
				4'd0:  r = 8'd6;
				4'd1:  r = 8'd7;
				4'd2:  r = 8'd8;
				4'd3:  r = 8'd10;
				4'd4:  r = 8'd15;
				4'd5:  r = 8'd20;
				4'd6:  r = 8'd25;
				4'd7:  r = 8'd30;
				4'd8:  r = 8'd40;
				4'd9:  r = 8'd50;
				4'd10: r = 8'd60;
				4'd11: r = 8'd70;
				4'd12: r = 8'd80;
				default: r = '0;
			endcase
		end
		return r;
	endfunction

	// Centimetres to millimetres as cm * 8 + cm * 2.
	function automatic logic [MM_W-1:0] cm_to_mm(input logic [CM_W-1:0] cm);
		return MM_W'({cm, 3'b000}) + MM_W'({cm, 1'b0});
	endfunction

endpackage
`default_nettype wire

// ----- rtl/rsc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rsc_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire rsc_pkg::dp_status_t st,
	output rsc_pkg::dp_cmd_t        cmd
);
	import rsc_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_LOOK;
				end
			end
			ST_LOOK: begin
				cmd.look = 1'b1;
				if (!st.is_sample) begin
					state_d = ST_COMMIT;
				end else if (st.clamp) begin
					state_d = ST_SCALE;
				end else begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				cmd.search = 1'b1;
				if (st.hit) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				if (st.div_last) begin
					state_d = ST_SUB;
				end
			end
			ST_SUB: begin
				cmd.sub = 1'b1;
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = ST_COMMIT;
			end
			ST_COMMIT: begin
				// Hold the finished item until the output register has room.
				if (st.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/rsc_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rsc_dp (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire rsc_pkg::dp_cmd_t           cmd,
	output rsc_pkg::dp_status_t             st,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_index,
	input  wire logic [2:0]                 cfg_data,
	input  wire logic [2:0]                 func,
	input  wire logic [7:0]                 adc_code,
	input  wire logic                       echo_level,
	input  wire logic [rsc_pkg::SLOT_W-1:0] read_slot,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic                            slot_written,
	output logic [rsc_pkg::SLOT_W-1:0]      written_index,
	output logic [7:0]                      written_distance,
	output logic [2:0]                      mux_code,
	output logic                            start_conversion,
	output logic                            fire_trigger,
	output logic                            scan_done,
	output logic [7:0]                      read_distance
);
	import rsc_pkg::*;

	// Latched item.
	logic [2:0]        func_q;
	logic [7:0]        code_q;
	logic              level_q;
	logic [SLOT_W-1:0] rslot_q;

	// Scanner state.
	logic [SLOT_W-1:0] long_slot_q, last_slot_q, cur_slot_q;
	logic [CM_W-1:0]   buf_q [SLOTS];
	logic [7:0]        timer_q;
	logic              done_q;

	// Lookup datapath.
	logic [IDX_W-1:0]  j_q;
	logic [MM_W-1:0]   high_q, diff_q, mm_q;
	logic [VOLT_W-1:0] dv_q, den_q;
	logic [NUM_W-1:0]  num_q;
	logic [REM_W-1:0]  rem_q;
	logic [DSH_W-1:0]  dsh_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [QUO_W-1:0]  quo_q;
	logic [CM_W-1:0]   cm_q;

	logic              out_valid_q;

	logic [VOLT_W-1:0] v, volt_a, volt_b;
	logic [CM_W-1:0]   cm_a, cm_b;
	logic [IDX_W-1:0]  idx_a, idx_b, last_idx;
	logic              sel_long, div_ge;
	logic [PROD_W-1:0] prod;

	assign v        = {code_q, 8'b0};
	assign sel_long = (cur_slot_q == long_slot_q);
	assign last_idx = sel_long ? IDX_W'(LONG_POINTS - 1) : IDX_W'(SHORT_POINTS - 1);

	// During the first look, a is the first breakpoint and b the last one;
	// during the search, a and b bound the segment under test.
	assign idx_a  = cmd.look ? '0 : j_q - IDX_W'(1);
	assign idx_b  = cmd.look ? last_idx : j_q;
	assign volt_a = bp_volt(sel_long, idx_a);
	assign volt_b = bp_volt(sel_long, idx_b);
	assign cm_a   = bp_cm(sel_long, idx_a);
	assign cm_b   = bp_cm(sel_long, idx_b);

	assign div_ge = (rem_q >= REM_W'(dsh_q));
	assign prod   = PROD_W'(mm_q) * PROD_W'(RECIP_10);

	assign st.is_sample = (func_q == FUNC_SAMPLE);
	assign st.clamp     = (v >= volt_a) || (v <= volt_b);
	assign st.hit       = (v >= volt_b);
	assign st.div_last  = (cnt_q == '0);
	assign st.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func;
			code_q  <= adc_code;
			level_q <= echo_level;
			rslot_q <= read_slot;
		end
		if (cmd.look) begin
			j_q <= IDX_W'(1);
			if (v >= volt_a) begin
				mm_q <= cm_to_mm(cm_a);
			end else begin
				mm_q <= cm_to_mm(cm_b);
			end
		end
		if (cmd.search) begin
			j_q    <= j_q + IDX_W'(1);
			high_q <= cm_to_mm(cm_a);
			diff_q <= cm_to_mm(cm_b) - cm_to_mm(cm_a);
			dv_q   <= volt_a - v;
			den_q  <= volt_a - volt_b;
		end
		if (cmd.mul) begin
			num_q <= NUM_W'(diff_q) * NUM_W'(dv_q);
		end
		if (cmd.prep) begin
			// Distance grows away from the nearer breakpoint, so the quotient is truncated.
			rem_q <= REM_W'(num_q);
			dsh_q <= {den_q, (QUO_W - 1)'(0)};
			cnt_q <= CNT_W'(QUO_W - 1);
			quo_q <= '0;
		end
		if (cmd.div) begin
			if (div_ge) begin
				rem_q <= rem_q - REM_W'(dsh_q);
			end
			quo_q <= {quo_q[QUO_W-2:0], div_ge};
			dsh_q <= dsh_q >> 1;
			cnt_q <= cnt_q - CNT_W'(1);
		end
		if (cmd.sub) begin
			mm_q <= high_q + quo_q;
		end
		if (cmd.scale) begin
			cm_q <= prod[PROD_W-1:PROD_W-CM_W];
		end
	end

	// Next architectural state and result of the item, used on commit.
	logic [SLOT_W-1:0] cur_d;
	logic [7:0]        timer_d;
	logic              done_d, wr_d, conv_d, fire_d;
	logic [SLOT_W-1:0] widx_d;
	logic [7:0]        wdist_d;
	logic [CM_W-1:0]   buf_d [SLOTS];

	always_comb begin
		cur_d   = cur_slot_q;
		timer_d = timer_q;
		done_d  = done_q;
		wr_d    = 1'b0;
		widx_d  = '0;
		wdist_d = '0;
		conv_d  = 1'b0;
		fire_d  = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			buf_d[i] = buf_q[i];
		end
		unique case (func_q)
			FUNC_START: begin
				cur_d  = '0;
				conv_d = 1'b1;
			end
			FUNC_SAMPLE: begin
				buf_d[cur_slot_q] = cm_q;
				wr_d    = 1'b1;
				widx_d  = cur_slot_q;
				wdist_d = cm_q;
				if (cur_slot_q < last_slot_q) begin
					cur_d  = cur_slot_q + SLOT_W'(1);
					conv_d = 1'b1;
				end else begin
					cur_d   = '0;
					timer_d = '0;
					fire_d  = 1'b1;
				end
			end
			FUNC_ECHO: begin
				if (level_q) begin
					timer_d = '0;
				end else begin
					buf_d[ECHO_SLOT] = timer_q;
					done_d  = 1'b1;
					wr_d    = 1'b1;
					widx_d  = ECHO_SLOT;
					wdist_d = timer_q;
				end
			end
			FUNC_TICK: begin
				timer_d = timer_q + 8'd1;
			end
			FUNC_CLEAR: begin
				done_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_slot_q <= 3'd4;
			last_slot_q <= 3'd6;
			cur_slot_q  <= '0;
			timer_q     <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				buf_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_LONG_SLOT: long_slot_q <= cfg_data;
					CFG_LAST_SLOT: last_slot_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.commit) begin
				cur_slot_q <= cur_d;
				timer_q    <= timer_d;
				done_q     <= done_d;
				for (int i = 0; i < SLOTS; i++) begin
					buf_q[i] <= buf_d[i];
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output register; loaded only when the previous result has left.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			slot_written     <= wr_d;
			written_index    <= widx_d;
			written_distance <= wdist_d;
			mux_code         <= (cur_d <= MUX_LAST) ? cur_d + SLOT_W'(1) : '0;
			start_conversion <= conv_d;
			fire_trigger     <= fire_d;
			scan_done        <= done_d;
			read_distance    <= buf_d[rslot_q];
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ----- rtl/ir_ultrasonic_range_scanner.sv -----
`timescale 1ns / 1ps
`default_nettype none
// IR and ultrasonic range scanner.
// Items enter on in_valid/in_ready: func selects start scan, ADC sample, echo
// edge, timer tick, clear done or read slot, with adc_code, echo_level and
// read_slot alongside. Each accepted item gives exactly one result transfer on
// out_valid/out_ready carrying the stored distance (if any), the next mux
// select, conversion and trigger requests, the done flag and the buffer entry
// at read_slot as it stands after the item.
// An ADC sample that clamps to an end of the table goes from the look step to
// scaling; otherwise it searches the segments one breakpoint at a time, then
// multiplies, runs a serial divide and adds. Other items go straight to commit.
// One item is in work at a time; in_ready is high only while the block is idle.
// The result sits in an output register, so the next item is accepted while an
// earlier result waits; if the receiver still holds the result when the next
// one finishes, the block waits until that transfer completes.
// The configuration port (cfg_we, cfg_index, cfg_data) sets the long-range
// slot (index 0) and the last IR slot (index 1); write it only when idle.
// Reset clears the buffer, timer, slot counter and done flag, sets the
// long-range slot to 4 and the last IR slot to 6, and empties the output.
module ir_ultrasonic_range_scanner (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_index,
	input  wire logic [2:0]                 cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [2:0]                 func,
	input  wire logic [7:0]                 adc_code,
	input  wire logic                       echo_level,
	input  wire logic [rsc_pkg::SLOT_W-1:0] read_slot,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic                            slot_written,
	output logic [rsc_pkg::SLOT_W-1:0]      written_index,
	output logic [7:0]                      written_distance,
	output logic [2:0]                      mux_code,
	output logic                            start_conversion,
	output logic                            fire_trigger,
	output logic                            scan_done,
	output logic [7:0]                      read_distance
);
	import rsc_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t st;

	rsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	rsc_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.st               (st),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.func             (func),
		.adc_code         (adc_code),
		.echo_level       (echo_level),
		.read_slot        (read_slot),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.slot_written     (slot_written),
		.written_index    (written_index),
		.written_distance (written_distance),
		.mux_code         (mux_code),
		.start_conversion (start_conversion),
		.fire_trigger     (fire_trigger),
		.scan_done        (scan_done),
		.read_distance    (read_distance)
	);

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;
	import rsc_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 6;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 300;
	localparam int MAX_REPORTS   = 10;
	localparam int PHASE_ITEMS   = 100;
	localparam longint TIMEOUT_NS = 4_000_000;

	localparam logic [2:0] FUNC_READ   = 3'd5;
	localparam logic [2:0] FUNC_NOP_LO = 3'd6;
	localparam logic [2:0] FUNC_NOP_HI = 3'd7;

	// Breakpoints as {volt, cm}, entry 0 first (highest voltage, nearest distance).
	localparam logic [0:SHORT_POINTS-1][23:0] SHORT_BP = {
		{16'd41288, 8'd6},  {16'd39059, 8'd7},  {16'd36045, 8'd8},
		{16'd30278, 8'd10}, {16'd21496, 8'd15}, {16'd17170, 8'd20},
		{16'd14156, 8'd25}, {16'd12059, 8'd30}, {16'd9699, 8'd40},
		{16'd7995, 8'd50},  {16'd6685, 8'd60},  {16'd5898, 8'd70},
		{16'd5374, 8'd80}
	};
	localparam logic [0:LONG_POINTS-1][23:0] LONG_BP = {
		{16'd36045, 8'd15}, {16'd33423, 8'd20}, {16'd26214, 8'd30},
		{16'd20316, 8'd40}, {16'd16384, 8'd50}, {16'd14025, 8'd60},
		{16'd11141, 8'd70}, {16'd10486, 8'd80}, {16'd9830, 8'd90},
		{16'd8520, 8'd100}, {16'd7864, 8'd110}, {16'd7209, 8'd120},
		{16'd6554, 8'd130}, {16'd5898, 8'd140}, {16'd5505, 8'd150}
	};

	typedef struct packed {
		logic       written;
		logic [2:0] index;
		logic [7:0] distance;
		logic [2:0] mux;
		logic       conv;
		logic       fire;
		logic       done;
		logic [7:0] rd;
	} scan_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_index = CFG_LONG_SLOT;
	logic [2:0] cfg_data = 3'd0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [2:0] func = FUNC_NOP_LO;
	logic [7:0] adc_code = 8'd0;
	logic       echo_level = 1'b0;
	logic [2:0] read_slot = 3'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       slot_written;
	logic [2:0] written_index;
	logic [7:0] written_distance;
	logic [2:0] mux_code;
	logic       start_conversion;
	logic       fire_trigger;
	logic       scan_done;
	logic [7:0] read_distance;

	// Scanner state as the testbench tracks it.
	logic [2:0] long_slot_cfg = 3'd4;
	logic [2:0] last_slot_cfg = 3'd6;
	logic [2:0] scan_slot = 3'd0;
	logic [7:0] echo_ticks = 8'd0;
	logic       done_bit = 1'b0;
	logic [7:0] dist_mem [SLOTS];

	scan_result_t expected_results[$];
	int mismatch_count = 0;
	int items_sent = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int rx_hold_cycles = 0;

	ir_ultrasonic_range_scanner u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.func             (func),
		.adc_code         (adc_code),
		.echo_level       (echo_level),
		.read_slot        (read_slot),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.slot_written     (slot_written),
		.written_index    (written_index),
		.written_distance (written_distance),
		.mux_code         (mux_code),
		.start_conversion (start_conversion),
		.fire_trigger     (fire_trigger),
		.scan_done        (scan_done),
		.read_distance    (read_distance)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [23:0] bp_point(input logic use_long, input int idx);
		return use_long ? LONG_BP[idx] : SHORT_BP[idx];
	endfunction

	function automatic logic [7:0] interp_cm(input logic use_long, input logic [7:0] code);
		logic [23:0] hi_pt, lo_pt, last_pt;
		longint v, hi_v, lo_v, mm, high, diff, num, den, q;
		int n, i;
		bit found;
		n = use_long ? LONG_POINTS : SHORT_POINTS;
		v = longint'({code, 8'h00});
		found = 1'b0;
		last_pt = bp_point(use_long, n - 1);
		hi_pt = bp_point(use_long, 0);
		mm = longint'(last_pt[7:0]) * 10;
		if (v >= longint'(hi_pt[23:8])) begin
			mm = longint'(hi_pt[7:0]) * 10;
		end else if (v > longint'(last_pt[23:8])) begin
			for (i = 0; i + 1 < n && !found; i++) begin
				hi_pt = bp_point(use_long, i);
				lo_pt = bp_point(use_long, i + 1);
				hi_v = longint'(hi_pt[23:8]);
				lo_v = longint'(lo_pt[23:8]);
				if (hi_v > v && v >= lo_v) begin
					high = longint'(hi_pt[7:0]) * 10;
					diff = high - longint'(lo_pt[7:0]) * 10;
					num = diff * (hi_v - v);
					den = hi_v - lo_v;
					// Ceiling for a positive step, truncation toward zero otherwise.
					if (num >= 0)
						q = (num + den - 1) / den;
					else
						q = -((-num) / den);
					mm = high - q;
					found = 1'b1;
				end
			end
		end
		if (mm < 0)
			mm = 0;
		mm = mm / 10;
		if (mm > 255)
			mm = 255;
		return 8'(mm);
	endfunction

	function automatic scan_result_t predict_scan_step(input logic [2:0] op,
			input logic [7:0] code, input logic level, input logic [2:0] rslot);
		scan_result_t r;
		logic [2:0] s;
		r = '0;
		case (op)
			FUNC_START: begin
				scan_slot = 3'd0;
				r.conv = 1'b1;
			end
			FUNC_SAMPLE: begin
				s = scan_slot;
				r.written = 1'b1;
				r.index = s;
				r.distance = interp_cm(s == long_slot_cfg, code);
				dist_mem[s] = r.distance;
				if (s < last_slot_cfg) begin
					scan_slot = s + 3'd1;
					r.conv = 1'b1;
				end else begin
					scan_slot = 3'd0;
					echo_ticks = 8'd0;
					r.fire = 1'b1;
				end
			end
			FUNC_ECHO: begin
				if (level) begin
					echo_ticks = 8'd0;
				end else begin
					dist_mem[ECHO_SLOT] = echo_ticks;
					done_bit = 1'b1;
					r.written = 1'b1;
					r.index = ECHO_SLOT;
					r.distance = echo_ticks;
				end
			end
			FUNC_TICK: echo_ticks = echo_ticks + 8'd1;
			FUNC_CLEAR: done_bit = 1'b0;
			default: ;
		endcase
		r.mux = (scan_slot <= MUX_LAST) ? scan_slot + 3'd1 : 3'd0;
		r.done = done_bit;
		r.rd = dist_mem[rslot];
		return r;
	endfunction

	function automatic void flag_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $time, msg);
	endfunction

	function automatic void check_result(input scan_result_t got);
		scan_result_t exp;
		string diffs;
		if (expected_results.size() == 0) begin
			flag_mismatch($sformatf("result with nothing pending: written %0d index %0d dist %0d",
				got.written, got.index, got.distance));
			return;
		end
		exp = expected_results.pop_front();
		diffs = "";
		if (got.written !== exp.written)
			diffs = {diffs, $sformatf(" slot_written exp %0d got %0d", exp.written, got.written)};
		if (got.index !== exp.index)
			diffs = {diffs, $sformatf(" written_index exp %0d got %0d", exp.index, got.index)};
		if (got.distance !== exp.distance)
			diffs = {diffs, $sformatf(" written_distance exp %0d got %0d",
				exp.distance, got.distance)};
		if (got.mux !== exp.mux)
			diffs = {diffs, $sformatf(" mux_code exp %0d got %0d", exp.mux, got.mux)};
		if (got.conv !== exp.conv)
			diffs = {diffs, $sformatf(" start_conversion exp %0d got %0d", exp.conv, got.conv)};
		if (got.fire !== exp.fire)
			diffs = {diffs, $sformatf(" fire_trigger exp %0d got %0d", exp.fire, got.fire)};
		if (got.done !== exp.done)
			diffs = {diffs, $sformatf(" scan_done exp %0d got %0d", exp.done, got.done)};
		if (got.rd !== exp.rd)
			diffs = {diffs, $sformatf(" read_distance exp %0d got %0d", exp.rd, got.rd)};
		if (diffs != "")
			flag_mismatch({"result fields:", diffs});
	endfunction

	// Near a breakpoint one time in three, an end of the code range now and then.
	function automatic logic [7:0] pick_adc_code();
		logic [23:0] pt;
		logic use_long;
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return $urandom_range(1) ? 8'hFF : 8'h00;
		if (r < 40) begin
			use_long = 1'($urandom);
			pt = bp_point(use_long, use_long ? $urandom_range(LONG_POINTS - 1)
				: $urandom_range(SHORT_POINTS - 1));
			return 8'(int'(pt[23:16]) + $urandom_range(2) - 1);
		end
		return 8'($urandom);
	endfunction

	// Offers one item and returns at the edge where the transfer happens, valid still high.
	task automatic send_op(input logic [2:0] op, input logic [7:0] code, input logic level,
			input logic [2:0] rslot);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= op;
		adc_code <= code;
		echo_level <= level;
		read_slot <= rslot;
		do
			@(posedge clk);
		while (!in_ready);
		expected_results.push_back(predict_scan_step(op, code, level, rslot));
		items_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_scan_regs(input logic [2:0] long_slot, input logic [2:0] last_slot);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= CFG_LONG_SLOT;
		cfg_data <= long_slot;
		@(posedge clk);
		cfg_index <= CFG_LAST_SLOT;
		cfg_data <= last_slot;
		@(posedge clk);
		cfg_we <= 1'b0;
		long_slot_cfg = long_slot;
		last_slot_cfg = last_slot;
	endtask

	task automatic test_reset_state();
		// Mux select is 1 and the buffer is empty right after reset.
		send_op(FUNC_READ, 8'($urandom), 1'($urandom), 3'd0);
		send_op(FUNC_READ, 8'($urandom), 1'($urandom), 3'd7);
		send_op(FUNC_NOP_LO, 8'($urandom), 1'($urandom), 3'($urandom));
		send_op(FUNC_NOP_HI, 8'($urandom), 1'($urandom), 3'($urandom));
	endtask

	task automatic test_directed_scan();
		send_op(FUNC_START, 8'($urandom), 1'($urandom), 3'($urandom));
		send_op(FUNC_SAMPLE, 8'd255, 1'($urandom), 3'd0);
		send_op(FUNC_SAMPLE, 8'd0, 1'($urandom), 3'd1);
		// Ticks left over from before the trigger must not reach the echo count.
		send_op(FUNC_TICK, 8'($urandom), 1'($urandom), 3'($urandom));
		send_op(FUNC_TICK, 8'($urandom), 1'($urandom), 3'($urandom));
		send_op(FUNC_SAMPLE, 8'd21, 1'($urandom), 3'd2);
		send_op(FUNC_SAMPLE, 8'd161, 1'($urandom), 3'd3);
		send_op(FUNC_SAMPLE, 8'd140, 1'($urandom), 3'd4);
		send_op(FUNC_SAMPLE, 8'd128, 1'($urandom), 3'd5);
		send_op(FUNC_SAMPLE, 8'd20, 1'($urandom), 3'd6);
		send_op(FUNC_TICK, 8'($urandom), 1'($urandom), 3'($urandom));
		send_op(FUNC_ECHO, 8'($urandom), 1'b0, 3'd7);
		send_op(FUNC_ECHO, 8'($urandom), 1'b1, 3'($urandom));
		send_op(FUNC_TICK, 8'($urandom), 1'($urandom), 3'($urandom));
		send_op(FUNC_TICK, 8'($urandom), 1'($urandom), 3'($urandom));
		send_op(FUNC_ECHO, 8'($urandom), 1'b0, 3'd7);
		// A new scan keeps the done flag until it is cleared.
		send_op(FUNC_START, 8'($urandom), 1'($urandom), 3'($urandom));
		send_op(FUNC_CLEAR, 8'($urandom), 1'($urandom), 3'($urandom));
		send_op(FUNC_READ, 8'($urandom), 1'($urandom), 3'd4);
		send_op(FUNC_NOP_LO, 8'($urandom), 1'($urandom), 3'($urandom));
		send_op(FUNC_NOP_HI, 8'($urandom), 1'($urandom), 3'($urandom));
	endtask

	task automatic run_scan_sequence(input bit long_echo);
		int ticks, k;
		if (!long_echo && $urandom_range(99) < 15) begin
			repeat ($urandom_range(6, 1))
				send_op(3'($urandom), 8'($urandom), 1'($urandom), 3'($urandom));
			return;
		end
		if ($urandom_range(99) < 90)
			send_op(FUNC_START, 8'($urandom), 1'($urandom), 3'($urandom));
		for (k = 0; k <= int'(last_slot_cfg); k++) begin
			if ($urandom_range(99) < 8)
				send_op(3'($urandom), 8'($urandom), 1'($urandom), 3'($urandom));
			send_op(FUNC_SAMPLE, pick_adc_code(), 1'($urandom), 3'($urandom));
		end
		if (long_echo || $urandom_range(99) < 85) begin
			if ($urandom_range(99) < 80)
				send_op(FUNC_ECHO, 8'($urandom), 1'b1, 3'($urandom));
			// A long echo runs the tick counter close to or past its wrap.
			if (long_echo || $urandom_range(99) < 4)
				ticks = $urandom_range(270, 240);
			else
				ticks = $urandom_range(30);
			repeat (ticks) send_op(FUNC_TICK, 8'($urandom), 1'($urandom), 3'($urandom));
			send_op(FUNC_ECHO, 8'($urandom), 1'b0, 3'($urandom));
		end
		if ($urandom_range(99) < 30)
			send_op(FUNC_CLEAR, 8'($urandom), 1'($urandom), 3'($urandom));
		if ($urandom_range(99) < 30)
			send_op(FUNC_READ, 8'($urandom), 1'($urandom), 3'($urandom));
	endtask

	task automatic test_random_scans(input logic [2:0] long_slot, input logic [2:0] last_slot,
			input int item_count, input bit with_wrap);
		int stop_at;
		program_scan_regs(long_slot, last_slot);
		stop_at = items_sent + item_count;
		if (with_wrap)
			run_scan_sequence(1'b1);
		while (items_sent < stop_at)
			run_scan_sequence(1'b0);
	endtask

	task automatic test_output_backpressure();
		int saved_idle;
		saved_idle = send_idle_pct;
		send_idle_pct = 0;
		rx_hold_cycles = HOLD_CYCLES;
		repeat (24) send_op(3'($urandom), pick_adc_code(), 1'($urandom), 3'($urandom));
		send_idle_pct = saved_idle;
		drain_results();
	endtask

	initial begin : out_ready_driver
		int hold_left;
		forever begin
			@(posedge clk);
			if (rx_hold_cycles != 0) begin
				hold_left = rx_hold_cycles;
				rx_hold_cycles = 0;
				out_ready <= 1'b0;
				repeat (hold_left - 1) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin : result_checker
		scan_result_t got;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				got = {slot_written, written_index, written_distance, mux_code,
					start_conversion, fire_trigger, scan_done, read_distance};
				check_result(got);
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		for (int i = 0; i < SLOTS; i++)
			dist_mem[i] = 8'd0;
		send_idle_pct = 36;
		recv_idle_pct = 56;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_directed_scan();
		test_random_scans(3'd0, 3'd0, PHASE_ITEMS, 1'b0);
		test_random_scans(3'd6, 3'd6, PHASE_ITEMS, 1'b0);
		test_output_backpressure();

		send_idle_pct = 56;
		recv_idle_pct = 36;
		test_random_scans(3'd6, 3'd0, PHASE_ITEMS, 1'b0);
		test_random_scans(3'd0, 3'd6, PHASE_ITEMS, 1'b0);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_scans(3'($urandom_range(6)), 3'($urandom_range(6)), PHASE_ITEMS, 1'b1);
		test_random_scans(3'($urandom_range(6)), 3'($urandom_range(6)), PHASE_ITEMS, 1'b0);

		drain_results();
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
